// File: sv/ascii_hex_frame_decoder_assert.svh
// assertion macros used by the checker file
`ifndef ASCII_HEX_FRAME_DECODER_ASSERT_SVH
`define ASCII_HEX_FRAME_DECODER_ASSERT_SVH

// same-cycle implication, disabled during reset
`define AFD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define AFD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: sv/afd_pkg.sv
// shared types and constants of the ascii hex frame decoder
package afd_pkg;

   // frame characters
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_UA    = 8'h41;
   localparam logic [7:0] CH_UF    = 8'h46;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LFH   = 8'h66;

   localparam logic [7:0] MAX_CHARS_RESET = 8'hFF;
   localparam logic [7:0] COUNT_MAX       = 8'hFF;

   // frame phase
   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_HIGH = 2'd1,
      PH_LOW  = 2'd2,
      PH_LF   = 2'd3
   } phase_type;

   // result kind codes
   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   // one decoded result from the core
   typedef struct packed {
      logic       valid;
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] byte_count;
   } result_type;

endpackage

// File: sv/ascii_hex_frame_decoder.sv
// ascii hex frame decoder: a character is accepted into the input register, then decoded into the result register
// throughput: one character per cycle while no held result is stalled, set by the single decode stage
// characters that end no byte or frame and raise no error give no result transaction
// synchronous active-high reset returns to idle, clears both valid flags
// and sets max_chars to 255
module ascii_hex_frame_decoder import afd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [7:0] rsp_byte_count,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic       stage_valid;
   logic [7:0] stage_char;
   logic       out_free;
   logic       fire;
   result_type result;

   logic [7:0] max_chars_ff, max_chars_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [1:0] rsp_kind_ff, rsp_kind_in;
   logic [7:0] rsp_data_ff, rsp_data_in;
   logic [7:0] rsp_count_ff, rsp_count_in;

   // output register is free when empty or taken this cycle
   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign fire     = stage_valid & out_free;

   afd_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_char_in (req_char_in),
      .advance     (out_free),
      .req_stall   (req_stall),
      .stage_valid (stage_valid),
      .stage_char  (stage_char)
   );

   afd_core u_core (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .char_in   (stage_char),
      .max_chars (max_chars_ff),
      .result    (result)
   );

   // configuration register, always ready
   assign csr_ready = 1'b1;
   assign max_chars_in = (csr_valid && csr_ready) ? csr_data : max_chars_ff;

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_count_in = rsp_count_ff;
      if (out_free) begin
         rsp_valid_in = fire & result.valid;
         rsp_kind_in  = result.kind;
         rsp_data_in  = result.data_byte;
         rsp_count_in = result.byte_count;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         max_chars_ff <= max_chars_in;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_data_byte  = rsp_data_ff;
   assign rsp_byte_count = rsp_count_ff;

endmodule

// File: sv/afd_in_stage.sv
// input register stage holding one accepted character
module afd_in_stage import afd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [7:0] req_char_in,
   input  logic       advance,
   output logic       req_stall,
   output logic       stage_valid,
   output logic [7:0] stage_char
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff, char_in;

   // hold while the decode stage cannot take the held character
   assign req_stall = valid_ff & ~advance;

   // next values of the input register
   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (!req_stall) begin
         valid_in = req_valid;
         if (req_valid) begin
            char_in = req_char_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign stage_valid = valid_ff;
   assign stage_char  = char_ff;

endmodule

// File: sv/afd_core.sv
// frame state machine and character decode
module afd_core import afd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] char_in,
   input  logic [7:0] max_chars,
   output result_type result
);

   phase_type  phase_ff, phase_in;
   logic [3:0] high_nibble_ff, high_nibble_in;
   logic [7:0] bytes_seen_ff, bytes_seen_in;
   logic [3:0] nibble;
   logic       over_limit;

   // hex digit value, zero for anything else
   function automatic logic [3:0] hex_value(input logic [7:0] c);
      logic [7:0] v;
      v = 8'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = c - CH_ZERO;
      end else if (c >= CH_UA && c <= CH_UF) begin
         v = c - CH_UA + 8'd10;
      end else if (c >= CH_LA && c <= CH_LFH) begin
         v = c - CH_LA + 8'd10;
      end
      return v[3:0];
   endfunction

   assign nibble = hex_value(char_in);

   // length limit, compared at nine bits so it cannot wrap
   assign over_limit = (bytes_seen_ff != 8'd0) &&
                       ({bytes_seen_ff, 1'b0} >= {1'b0, max_chars});

   // next state
   always_comb begin
      phase_in       = phase_ff;
      high_nibble_in = high_nibble_ff;
      bytes_seen_in  = bytes_seen_ff;
      if (fire) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (char_in == CH_COLON) begin
                  phase_in       = PH_HIGH;
                  bytes_seen_in  = 8'd0;
                  high_nibble_in = 4'd0;
               end
            end
            PH_HIGH: begin
               if (char_in == CH_CR) begin
                  phase_in = over_limit ? PH_IDLE : PH_LF;
               end else begin
                  high_nibble_in = nibble;
                  phase_in       = PH_LOW;
               end
            end
            PH_LOW: begin
               if (char_in == CH_CR || char_in == CH_LF) begin
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_HIGH;
                  if (bytes_seen_ff != COUNT_MAX) begin
                     bytes_seen_in = bytes_seen_ff + 8'd1;
                  end
               end
            end
            PH_LF: begin
               phase_in = PH_IDLE;
            end
            default: begin
               phase_in = PH_IDLE;
            end
         endcase
      end
   end

   // result of the character in the stage
   always_comb begin
      result = '{valid: 1'b0, kind: KIND_DATA, data_byte: 8'd0, byte_count: 8'd0};
      if (fire) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (char_in != CH_COLON) begin
                  result.valid = 1'b1;
                  result.kind  = KIND_ERR;
               end
            end
            PH_HIGH: begin
               if (char_in == CH_CR && over_limit) begin
                  result.valid = 1'b1;
                  result.kind  = KIND_ERR;
               end
            end
            PH_LOW: begin
               result.valid = 1'b1;
               if (char_in == CH_CR || char_in == CH_LF) begin
                  result.kind = KIND_ERR;
               end else begin
                  result.kind      = KIND_DATA;
                  result.data_byte = {high_nibble_ff, nibble};
               end
            end
            PH_LF: begin
               result.valid = 1'b1;
               if (char_in == CH_LF) begin
                  result.kind       = KIND_DONE;
                  result.byte_count = bytes_seen_ff;
               end else begin
                  result.kind = KIND_ERR;
               end
            end
            default: begin
               result.valid = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         high_nibble_ff <= 4'd0;
         bytes_seen_ff  <= 8'd0;
      end else begin
         phase_ff       <= phase_in;
         high_nibble_ff <= high_nibble_in;
         bytes_seen_ff  <= bytes_seen_in;
      end
   end

endmodule

// File: sv/afd_checker.sv
// port-level checker for the ascii hex frame decoder, with its bind
`include "ascii_hex_frame_decoder_assert.svh"

module afd_checker import afd_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_data_byte,
   input logic [7:0] rsp_byte_count
);

   logic        rsp_wait;
   logic [18:0] rsp_word;
   logic        kind_known;
   logic        data_clear;
   logic        count_clear;

   // result side terms
   assign rsp_wait    = rsp_valid && rsp_stall;
   assign rsp_word    = {rsp_valid, rsp_kind, rsp_data_byte, rsp_byte_count};
   assign kind_known  = (rsp_kind == KIND_DATA) || (rsp_kind == KIND_DONE) ||
                        (rsp_kind == KIND_ERR);
   assign data_clear  = (rsp_kind == KIND_DATA) || (rsp_data_byte == 8'd0);
   assign count_clear = (rsp_kind == KIND_DONE) || (rsp_byte_count == 8'd0);

   // a stalled result transaction holds
   `AFD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_wait, $stable(rsp_word), "held result changed")

   // only the three defined kinds appear
   `AFD_ASSERT_NOW(a_kind_code, clock, reset, rsp_valid, kind_known, "undefined result kind")

   // data byte is zero unless the result is data
   `AFD_ASSERT_NOW(a_data_zero, clock, reset, rsp_valid, data_clear, "stray data byte")

   // byte count is zero unless the frame completed
   `AFD_ASSERT_NOW(a_count_zero, clock, reset, rsp_valid, count_clear, "stray byte count")

   // input only stalls behind a stalled result
   `AFD_ASSERT_NOW(a_stall_cause, clock, reset, req_stall, rsp_wait, "input stall without cause")

endmodule

bind ascii_hex_frame_decoder afd_checker u_afd_checker (.*);

// File: tb/tb_top.sv
// self-checking testbench for the ascii hex frame decoder
module tb_top;
   import afd_pkg::*;

   localparam int ITEMS_TOTAL = 600;
   localparam int LONG_HOLD   = 300;
   localparam int CYCLE_LIMIT = 200000;
   localparam int SETTLE      = 4;

   // how a random frame is closed
   typedef enum int {
      FRAME_GOOD,
      FRAME_CUT,
      FRAME_NO_LF
   } frame_end_type;

   // one expected result transaction
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data_byte;
      logic [7:0] byte_count;
   } frame_result_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_data_byte;
   logic [7:0] rsp_byte_count;
   logic       csr_valid = 1'b0;
   logic       csr_ready;
   logic [7:0] csr_data = 8'h00;

   // decoder model state and its copy of the register
   phase_type  frame_phase = PH_IDLE;
   logic [3:0] held_nibble = 4'h0;
   logic [7:0] bytes_seen = 8'h00;
   logic [7:0] cfg_max_chars = MAX_CHARS_RESET;

   frame_result_type awaited_results[$];
   int    fail_count = 0;
   int    items_sent = 0;
   int    cycle_count = 0;
   int    stall_left = 0;
   bit    idle_on = 1'b1;
   bit    hold_request = 1'b0;
   string hex_chars = "0123456789ABCDEFabcdef";

   ascii_hex_frame_decoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_char_in    (req_char_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_kind       (rsp_kind),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_byte_count (rsp_byte_count),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_data       (csr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // run-length guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // value of one character taken as a nibble, zero when not a hex digit
   function automatic logic [3:0] nibble_of(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE)
         return 4'(c - CH_ZERO);
      if (c >= CH_UA && c <= CH_UF)
         return 4'(c - CH_UA + 8'd10);
      if (c >= CH_LA && c <= CH_LFH)
         return 4'(c - CH_LA + 8'd10);
      return 4'h0;
   endfunction

   // advance the frame model by one character, queue the result it gives
   function void decode_char(logic [7:0] c);
      frame_result_type r;
      bit               emit;
      emit = 1'b0;
      r = '{KIND_ERR, 8'h00, 8'h00};
      case (frame_phase)
         PH_IDLE: begin
            if (c == CH_COLON) begin
               frame_phase = PH_HIGH;
               bytes_seen = 8'h00;
               held_nibble = 4'h0;
            end else begin
               emit = 1'b1;
            end
         end
         PH_HIGH: begin
            if (c == CH_CR) begin
               // length limit, compared at nine bits so it cannot wrap
               if (bytes_seen != 8'h00 && {bytes_seen, 1'b0} >= {1'b0, cfg_max_chars}) begin
                  frame_phase = PH_IDLE;
                  emit = 1'b1;
               end else begin
                  frame_phase = PH_LF;
               end
            end else begin
               held_nibble = nibble_of(c);
               frame_phase = PH_LOW;
            end
         end
         PH_LOW: begin
            emit = 1'b1;
            if (c == CH_CR || c == CH_LF) begin
               frame_phase = PH_IDLE;
            end else begin
               r.kind = KIND_DATA;
               r.data_byte = {held_nibble, nibble_of(c)};
               if (bytes_seen != COUNT_MAX)
                  bytes_seen++;
               frame_phase = PH_HIGH;
            end
         end
         default: begin
            emit = 1'b1;
            frame_phase = PH_IDLE;
            if (c == CH_LF) begin
               r.kind = KIND_DONE;
               r.byte_count = bytes_seen;
            end
         end
      endcase
      if (emit)
         awaited_results.push_back(r);
   endfunction

   // predict on accepted characters, check accepted results
   always @(posedge clock) begin : result_check
      frame_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            decode_char(req_char_in);
         if (rsp_valid && !rsp_stall) begin
            stall_left = idle_on ? $urandom_range(0, 8) : 0;
            if (awaited_results.size() == 0) begin
               $error("unexpected result transaction: kind %0d", rsp_kind);
               fail_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_kind !== want.kind) begin
                  $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
                  fail_count++;
               end
               if (rsp_data_byte !== want.data_byte) begin
                  $error("data_byte: expected %0h, actual %0h", want.data_byte, rsp_data_byte);
                  fail_count++;
               end
               if (rsp_byte_count !== want.byte_count) begin
                  $error("byte_count: expected %0d, actual %0d", want.byte_count,
                         rsp_byte_count);
                  fail_count++;
               end
            end
         end
      end
   end

   // receiver: per-result stall draws plus an occasional long hold-off
   initial begin : rsp_side
      int hold_left;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // offer one character and wait until it is taken
   task send_char(input logic [7:0] c);
      int gap;
      gap = idle_on ? $urandom_range(0, 8) : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
   endtask

   task send_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_char(s[i]);
   endtask

   // stop offering and wait until every expected result has come
   task drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   task write_max_chars(input logic [7:0] value);
      drain_results();
      csr_valid <= 1'b1;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      cfg_max_chars = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // mostly hex digits of both cases, now and then any byte
   function automatic logic [7:0] nibble_char();
      if ($urandom_range(0, 9) == 0)
         return 8'($urandom_range(0, 255));
      return hex_chars[$urandom_range(0, 21)];
   endfunction

   task send_random_frame(input int pairs, input frame_end_type ending);
      send_char(CH_COLON);
      for (int i = 0; i < pairs; i++) begin
         send_char(nibble_char());
         send_char(nibble_char());
      end
      case (ending)
         FRAME_GOOD: begin
            send_char(CH_CR);
            send_char(CH_LF);
         end
         FRAME_CUT: begin
            send_char(nibble_char());
            send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
         end
         default: begin
            send_char(CH_CR);
            send_char(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   // stray characters, both hex cases, non-hex nibbles and frame endings
   task test_directed_frames();
      send_char(8'h00);
      send_char(8'hFF);
      send_text(":00Ffa9");
      send_char(CH_CR);
      send_char(CH_LF);
      // colon and LF taken as nibbles, then CR not followed by LF
      send_text(":G:");
      send_char(CH_LF);
      send_char("1");
      send_char(CH_CR);
      send_char("x");
      // CR or LF in the low nibble
      send_text(":5");
      send_char(CH_CR);
      send_text(":5");
      send_char(CH_LF);
      // empty frame
      send_char(CH_COLON);
      send_char(CH_CR);
      send_char(CH_LF);
   endtask

   // length limit at the register extremes and around one and two bytes
   task test_length_limit();
      write_max_chars(8'd0);
      send_text(":12");
      send_char(CH_CR);
      send_char(CH_COLON);
      send_char(CH_CR);
      send_char(CH_LF);
      write_max_chars(8'd1);
      send_text(":12");
      send_char(CH_CR);
      write_max_chars(8'd2);
      send_text(":12");
      send_char(CH_CR);
      write_max_chars(8'd3);
      send_text(":12");
      send_char(CH_CR);
      send_char(CH_LF);
      send_text(":1234");
      send_char(CH_CR);
      write_max_chars(8'd255);
      send_text(":abCD");
      send_char(CH_CR);
      send_char(CH_LF);
   endtask

   // receiver holds off while the sender keeps pushing a long frame
   task test_backpressure();
      idle_on = 1'b0;
      @(posedge clock);
      hold_request = 1'b1;
      send_random_frame(64, FRAME_GOOD);
      drain_results();
      idle_on = 1'b1;
      send_random_frame(3, FRAME_GOOD);
   endtask

   task test_random_traffic();
      int sel;
      while (items_sent < ITEMS_TOTAL) begin
         sel = $urandom_range(0, 99);
         if (sel < 5) begin
            if ($urandom_range(0, 1) != 0)
               write_max_chars(8'($urandom_range(0, 24)));
            else
               write_max_chars(8'($urandom_range(0, 255)));
         end else if (sel < 8) begin
            idle_on = ($urandom_range(0, 3) != 0);
         end else if (sel < 10) begin
            drain_results();
         end else if (sel < 18) begin
            send_char(8'($urandom_range(0, 255)));
         end else if (sel < 24) begin
            send_random_frame($urandom_range(0, 6), FRAME_CUT);
         end else if (sel < 29) begin
            send_random_frame($urandom_range(0, 6), FRAME_NO_LF);
         end else if (sel < 31) begin
            send_random_frame($urandom_range(100, 140), FRAME_GOOD);
         end else begin
            send_random_frame($urandom_range(0, 10), FRAME_GOOD);
         end
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_length_limit();
      test_backpressure();
      test_random_traffic();
      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && awaited_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
